// ===== hdl/tljm_pkg.sv =====
// Shared types and constants for the timing latency and jitter monitor.
package tljm_pkg;

    localparam int TIME_W  = 32;
    localparam int SUM_W   = 64;
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = SUM_W + FRAC_W;
    localparam int DVS_W   = 32;
    localparam int QUO_W   = 40;
    localparam int RATE_W  = 15;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_LATENCY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRIVAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEADLINE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    localparam logic REG_NOMINAL_PERIOD    = 1'b0;
    localparam logic REG_RELATIVE_DEADLINE = 1'b1;

    localparam logic [TIME_W-1:0] CNT_MAX        = 32'hFFFF_FFFF;
    localparam logic [RATE_W-1:0] PERCENT_Q8     = 15'd25600;
    localparam logic [30:0]       PERIOD_RESET   = 31'd10000;
    localparam logic [31:0]       DEADLINE_RESET = 32'd10000;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/tljm_div.sv =====
// Shared radix-4 restoring divider, two quotient bits per cycle.
module tljm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tljm_pkg::div_req_t req,
    output tljm_pkg::div_rsp_t rsp
);
    import tljm_pkg::*;

    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [DVS_W:0]   r1;
    logic [DVS_W:0]   r2;
    logic             ge1;
    logic             ge2;
    logic [DVS_W-1:0] r1n;
    logic [DVS_W-1:0] r2n;

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[DVD_W-1]};
        ge1 = (r1 >= {1'b0, dvs_reg});
        r1n = ge1 ? DVS_W'(r1 - {1'b0, dvs_reg}) : r1[DVS_W-1:0];
        r2  = {r1n, dvd_reg[DVD_W-2]};
        ge2 = (r2 >= {1'b0, dvs_reg});
        r2n = ge2 ? DVS_W'(r2 - {1'b0, dvs_reg}) : r2[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (req.start)
            begin
                done_reg <= (req.divisor == '0);
                if (req.divisor != '0)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(STEPS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            dvd_reg <= req.dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2n;
            dvd_reg <= {dvd_reg[DVD_W-3:0], 2'b00};
            quo_reg <= {quo_reg[QUO_W-3:0], ge1, ge2};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/timing_latency_jitter_monitor.sv =====
// Top level of the timing monitor: event sequencer, statistics and result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: func; tdata: time_start, time_end
//  m_       | out | m_tvalid/m_tready  | tuser: event_kind; tdata: result fields
//  cfg_     | in  | cfg_we             | cfg_addr: 0 nominal_period, 1 relative_deadline
//
// An event steps through the diff, meas, upd, load, div and out states; the divide
// state (36 radix-4 steps over a 72-bit dividend, plus start and done) computes the
// average or the miss rate. With a zero divisor (no jitter samples yet) the divider
// signals done without stepping. An event of unknown kind skips from diff to out.
// s_tready is high only while the sequencer is idle. A finished result sits in the
// output register while the next event is taken; the sequencer holds before writing
// the register if the previous result has not been transferred.
// Reset clears all statistics and loads both registers with 10000.
module timing_latency_jitter_monitor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // [1:0] func
    input  logic [63:0]  s_tdata,   // [31:0] time_start, [63:32] time_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [1:0]   m_tuser,   // [1:0] event_kind
    output logic [215:0] m_tdata,   // [0] updated, [32:1] measured, [64:33] sample_count,
                                    // [96:65] max_seen, [128:97] min_seen,
                                    // [168:129] average_q8, [200:169] miss_count,
                                    // [215:201] miss_rate_q8
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_data
);
    import tljm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MEAS = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int PROD_W = TIME_W + RATE_W;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [30:0]       period_reg;
    logic [TIME_W-1:0] deadline_reg;

    logic [SUM_W-1:0]  lat_sum_reg;
    logic [TIME_W-1:0] lat_cnt_reg;
    logic [TIME_W-1:0] lat_max_reg;
    logic [TIME_W-1:0] lat_min_reg;
    logic [SUM_W-1:0]  jit_sum_reg;
    logic [TIME_W-1:0] jit_cnt_reg;
    logic [TIME_W-1:0] jit_max_reg;
    logic [TIME_W-1:0] last_arr_reg;
    logic              seen_reg;
    logic [TIME_W-1:0] dl_total_reg;
    logic [TIME_W-1:0] dl_miss_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [TIME_W-1:0] ts_reg;
    logic [TIME_W-1:0] te_reg;
    logic [TIME_W-1:0] diff_reg;
    logic [TIME_W-1:0] meas_reg;
    logic              upd_reg;

    logic              start_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              m_tvalid_reg;
    logic [1:0]        m_tuser_reg;
    logic [215:0]      m_tdata_reg;

    logic [TIME_W-1:0] period_ext;
    logic [TIME_W-1:0] slack;
    logic [PROD_W-1:0] miss_prod;
    logic              out_free;
    logic [215:0]      out_data;

    assign period_ext = {1'b0, period_reg};
    assign slack      = diff_reg - te_reg;
    assign miss_prod  = PROD_W'(dl_miss_reg) * PROD_W'(PERCENT_Q8);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_DIFF;
            ST_DIFF: state_next = (kind_reg == KIND_NONE) ? ST_OUT : ST_MEAS;
            ST_MEAS: state_next = ST_UPD;
            ST_UPD:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_LOAD);
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            deadline_reg <= DEADLINE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_NOMINAL_PERIOD)
                period_reg <= cfg_data[30:0];
            else
                deadline_reg <= cfg_data;
        end
    end

    // statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_sum_reg  <= '0;
            lat_cnt_reg  <= '0;
            lat_max_reg  <= '0;
            lat_min_reg  <= '0;
            jit_sum_reg  <= '0;
            jit_cnt_reg  <= '0;
            jit_max_reg  <= '0;
            last_arr_reg <= '0;
            seen_reg     <= 1'b0;
            dl_total_reg <= '0;
            dl_miss_reg  <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            case (kind_reg)
                KIND_LATENCY:
                begin
                    if (lat_cnt_reg != CNT_MAX)
                    begin
                        lat_sum_reg <= lat_sum_reg + SUM_W'(meas_reg);
                        lat_cnt_reg <= lat_cnt_reg + 1'b1;
                    end
                    if (meas_reg > lat_max_reg)
                        lat_max_reg <= meas_reg;
                    if (lat_cnt_reg == '0 || meas_reg < lat_min_reg)
                        lat_min_reg <= meas_reg;
                end
                KIND_ARRIVAL:
                begin
                    if (seen_reg)
                    begin
                        if (jit_cnt_reg != CNT_MAX)
                        begin
                            jit_sum_reg <= jit_sum_reg + SUM_W'(meas_reg);
                            jit_cnt_reg <= jit_cnt_reg + 1'b1;
                        end
                        if (meas_reg > jit_max_reg)
                            jit_max_reg <= meas_reg;
                    end
                    last_arr_reg <= ts_reg;
                    seen_reg     <= 1'b1;
                end
                KIND_DEADLINE:
                begin
                    if (dl_total_reg != CNT_MAX)
                    begin
                        dl_total_reg <= dl_total_reg + 1'b1;
                        if (meas_reg[0])
                            dl_miss_reg <= dl_miss_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields for the output register
    always_comb
    begin
        out_data = '0;
        case (kind_reg)
            KIND_LATENCY:
            begin
                out_data[0]       = 1'b1;
                out_data[32:1]    = meas_reg;
                out_data[64:33]   = lat_cnt_reg;
                out_data[96:65]   = lat_max_reg;
                out_data[128:97]  = lat_min_reg;
                out_data[168:129] = div_rsp.quotient;
            end
            KIND_ARRIVAL:
            begin
                out_data[0]       = upd_reg;
                out_data[32:1]    = upd_reg ? meas_reg : '0;
                out_data[64:33]   = jit_cnt_reg;
                out_data[96:65]   = jit_max_reg;
                out_data[168:129] = div_rsp.quotient;
            end
            KIND_DEADLINE:
            begin
                out_data[0]       = 1'b1;
                out_data[32:1]    = meas_reg;
                out_data[64:33]   = dl_total_reg;
                out_data[200:169] = dl_miss_reg;
                out_data[215:201] = div_rsp.quotient[RATE_W-1:0];
            end
            default: ;
        endcase
    end

    // event datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            kind_reg <= s_tuser;
            ts_reg   <= s_tdata[31:0];
            te_reg   <= s_tdata[63:32];
        end

        if (state_reg == ST_DIFF)
        begin
            case (kind_reg)
                KIND_LATENCY:  diff_reg <= te_reg - ts_reg;
                KIND_ARRIVAL:  diff_reg <= ts_reg - last_arr_reg;
                KIND_DEADLINE: diff_reg <= ts_reg + deadline_reg;
                default:       diff_reg <= '0;
            endcase
        end

        if (state_reg == ST_MEAS)
        begin
            case (kind_reg)
                KIND_LATENCY:  meas_reg <= diff_reg;
                KIND_ARRIVAL:  meas_reg <= (diff_reg >= period_ext) ? diff_reg - period_ext
                                                                    : period_ext - diff_reg;
                KIND_DEADLINE: meas_reg <= {31'b0, slack[TIME_W-1]};
                default:       meas_reg <= '0;
            endcase
            upd_reg <= (kind_reg != KIND_ARRIVAL) || seen_reg;
        end

        if (state_reg == ST_LOAD)
        begin
            case (kind_reg)
                KIND_LATENCY:
                begin
                    dvd_reg <= {lat_sum_reg, FRAC_W'(0)};
                    dvs_reg <= lat_cnt_reg;
                end
                KIND_ARRIVAL:
                begin
                    dvd_reg <= {jit_sum_reg, FRAC_W'(0)};
                    dvs_reg <= jit_cnt_reg;
                end
                default:
                begin
                    dvd_reg <= DVD_W'(miss_prod);
                    dvs_reg <= dl_total_reg;
                end
            endcase
        end

        if (state_reg == ST_OUT && out_free)
        begin
            m_tuser_reg <= kind_reg;
            m_tdata_reg <= out_data;
        end
    end

    assign div_req.start    = start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;

    tljm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/tljm_chk.sv =====
// Port-level checker for the timing monitor, bound to the top level.
module tljm_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic [215:0] m_tdata
);
    import tljm_pkg::*;

    // one event in flight: no new transfer right after one is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while event in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[215:201] <= PERCENT_Q8)
        else $error("miss rate above 100 percent");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_NONE |-> m_tdata == '0)
        else $error("unknown kind reports nonzero fields");

    a_deadline_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DEADLINE |-> m_tdata[215:169] == '0)
        else $error("miss fields set on non-deadline result");

endmodule

bind timing_latency_jitter_monitor tljm_chk u_tljm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
